// ----- sv/apq_pkg.sv -----
// shared types and constants of the array priority queue
package apq_pkg;

  localparam int DEPTH_DEF = 8;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_DISPLAY = 2'd2,
    CMD_SORT    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] job_tag;
    logic [7:0]  job_priority;
    logic [15:0] arrival_order;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] out_tag;
    logic [7:0]  out_priority;
    logic [15:0] out_order;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [7:0]  prio;
    logic [15:0] ord;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/array_priority_queue.sv -----
// Array priority queue: a store of up to DEPTH jobs (tag, priority, arrival order).
// Requests arrive on cmd/cmd_valid/cmd_stall, results leave on rsp/rsp_valid/rsp_stall.
// A request is taken when valid is high and stall is low; cmd_stall stays high while
// the sequencer works on a request, so one request is handled at a time.
// Add: one result, status ok or full.
// Remove: scans every entry through the single ram read port,
//   then closes the gap one entry at a time; one result with the entry or empty.
// Display: one result per entry in slot order, last marks the final one;
//   an empty store gives one result with status empty.
// Sort: exchange pass over all slot pairs, then a display.
// Each step is paced by the one ram read port.
// Results sit in an output register: a stalled receiver holds the result and
// the sequencer waits before the next one.
// Reset empties the store (entry count to zero) and clears all handshake state;
// ram contents are left as they are and never read before being written.
module array_priority_queue #(
  parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  apq_pkg::req_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output apq_pkg::rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_RM_RD,
    S_RM_CMP,
    S_RM_SHIFT,
    S_RM_MOVE,
    S_SO_RDI,
    S_SO_LDI,
    S_SO_RDJ,
    S_SO_CMP,
    S_SO_WRI,
    S_DI_RD,
    S_DI_LD
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    i;
  logic [CW-1:0]    j;
  logic [CW-1:0]    best_idx;
  apq_pkg::entry_t  best;
  apq_pkg::entry_t  cur;
  apq_pkg::rsp_t    pend;

  logic                     accept;
  logic                     out_free;
  logic [CW-1:0]            i_inc;
  logic [CW-1:0]            j_inc;
  logic [CW-1:0]            cnt_inc;
  logic [CW-1:0]            cnt_dec;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  apq_pkg::entry_t          wr_data;
  logic [AW-1:0]            rd_addr;
  logic [apq_pkg::ENTRY_W-1:0] rd_raw;
  apq_pkg::entry_t          rd_entry;
  apq_pkg::entry_t          new_entry;
  logic                     rm_take;
  logic [CW-1:0]            best_idx_next;
  logic                     so_swap;
  apq_pkg::status_e         idle_status;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign i_inc     = i + 1'b1;
  assign j_inc     = j + 1'b1;
  assign cnt_inc   = cnt + 1'b1;
  assign cnt_dec   = cnt - 1'b1;
  assign rd_entry  = apq_pkg::entry_t'(rd_raw);

  assign new_entry.tag  = cmd.job_tag;
  assign new_entry.prio = cmd.job_priority;
  assign new_entry.ord  = cmd.arrival_order;

  // remove comparator: the scan keeps the later of equal priorities
  assign rm_take       = (i == '0) || (rd_entry.prio >= best.prio);
  assign best_idx_next = rm_take ? i : best_idx;

  // sort comparator: exchanges on priority, then arrival order
  assign so_swap = (cur.prio > rd_entry.prio) ||
                   ((cur.prio == rd_entry.prio) && (cur.ord > rd_entry.ord));

  // status of a newly taken request: full on add to a full store, empty on anything else with an empty store, else ok
  always_comb begin
    case (cmd.command)
      apq_pkg::CMD_ADD: idle_status = (cnt == FULL_CNT) ? apq_pkg::ST_FULL : apq_pkg::ST_OK;
      default:          idle_status = (cnt == '0) ? apq_pkg::ST_EMPTY : apq_pkg::ST_OK;
    endcase
  end

  // read address follows the sequencer step
  always_comb begin
    case (state)
      S_RM_SHIFT: rd_addr = i_inc[AW-1:0];
      S_SO_RDJ:   rd_addr = j[AW-1:0];
      default:    rd_addr = i[AW-1:0];
    endcase
  end

  // write port selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i[AW-1:0];
    wr_data = cur;
    case (state)
      S_IDLE: begin
        if (accept && cmd.command == apq_pkg::CMD_ADD && cnt != FULL_CNT) begin
          wr_en   = 1'b1;
          wr_addr = cnt[AW-1:0];
          wr_data = new_entry;
        end
      end
      S_RM_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = i[AW-1:0];
        wr_data = rd_entry;
      end
      S_SO_CMP: begin
        wr_en   = so_swap;
        wr_addr = j[AW-1:0];
        wr_data = cur;
      end
      S_SO_WRI: begin
        wr_en   = 1'b1;
        wr_addr = i[AW-1:0];
        wr_data = cur;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  apq_ram #(
    .WIDTH(apq_pkg::ENTRY_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  // sequencer, entry count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend.status       <= idle_status;
            pend.out_tag      <= '0;
            pend.out_priority <= '0;
            pend.out_order    <= '0;
            pend.last         <= 1'b1;
            i                 <= '0;
            case (cmd.command)
              apq_pkg::CMD_ADD: begin
                if (cnt != FULL_CNT) begin
                  cnt <= cnt_inc;
                end
                state <= S_EMIT;
              end
              apq_pkg::CMD_REMOVE: begin
                if (cnt == '0) begin
                  state <= S_EMIT;
                end else begin
                  state <= S_RM_RD;
                end
              end
              apq_pkg::CMD_SORT: begin
                if (cnt == '0) begin
                  state <= S_EMIT;
                end else if (cnt == CW'(1)) begin
                  state <= S_DI_RD;
                end else begin
                  state <= S_SO_RDI;
                end
              end
              default: begin
                if (cnt == '0) begin
                  state <= S_EMIT;
                end else begin
                  state <= S_DI_RD;
                end
              end
            endcase
          end
        end
        // hand the pending result to the output register
        S_EMIT: begin
          if (out_free) begin
            rsp       <= pend;
            rsp_valid <= 1'b1;
            state     <= pend.last ? S_IDLE : S_DI_RD;
          end
        end
        // remove: scan for the highest priority
        S_RM_RD: begin
          state <= S_RM_CMP;
        end
        S_RM_CMP: begin
          if (rm_take) begin
            best <= rd_entry;
          end
          best_idx <= best_idx_next;
          if (i_inc == cnt) begin
            i     <= best_idx_next;
            state <= S_RM_SHIFT;
          end else begin
            i     <= i_inc;
            state <= S_RM_RD;
          end
        end
        // remove: close the gap one entry at a time
        S_RM_SHIFT: begin
          if (i_inc == cnt) begin
            cnt               <= cnt_dec;
            pend.status       <= apq_pkg::ST_OK;
            pend.out_tag      <= best.tag;
            pend.out_priority <= best.prio;
            pend.out_order    <= best.ord;
            pend.last         <= 1'b1;
            state             <= S_EMIT;
          end else begin
            state <= S_RM_MOVE;
          end
        end
        S_RM_MOVE: begin
          i     <= i_inc;
          state <= S_RM_SHIFT;
        end
        // sort: hold slot i in cur and compare it against every later slot
        S_SO_RDI: begin
          state <= S_SO_LDI;
        end
        S_SO_LDI: begin
          cur   <= rd_entry;
          j     <= i_inc;
          state <= S_SO_RDJ;
        end
        S_SO_RDJ: begin
          state <= S_SO_CMP;
        end
        S_SO_CMP: begin
          if (so_swap) begin
            cur <= rd_entry;
          end
          j <= j_inc;
          state <= (j_inc == cnt) ? S_SO_WRI : S_SO_RDJ;
        end
        S_SO_WRI: begin
          if (i_inc + 1'b1 == cnt) begin
            i     <= '0;
            state <= S_DI_RD;
          end else begin
            i     <= i_inc;
            state <= S_SO_RDI;
          end
        end
        // display: one entry per result
        S_DI_RD: begin
          state <= S_DI_LD;
        end
        S_DI_LD: begin
          pend.status       <= apq_pkg::ST_OK;
          pend.out_tag      <= rd_entry.tag;
          pend.out_priority <= rd_entry.prio;
          pend.out_order    <= rd_entry.ord;
          pend.last         <= (i_inc == cnt);
          i                 <= i_inc;
          state             <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // the entry count never passes the store depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt <= FULL_CNT)
    else $error("entry count above depth");

  // an add on a full store leaves the count alone
  a_full_add: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == apq_pkg::CMD_ADD && cnt == FULL_CNT |=> cnt == FULL_CNT)
    else $error("add on full store changed the count");

  // a remove on an empty store goes straight to an empty result
  a_empty_rm: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.command == apq_pkg::CMD_REMOVE && cnt == '0
    |=> state == S_EMIT && pend.status == apq_pkg::ST_EMPTY && pend.last)
    else $error("remove on empty store mishandled");
`endif

endmodule

// ----- sv/apq_ram.sv -----
// generic single-write, single-read ram with registered read data
module apq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
